FILE: hdl/ffa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants of the first-fit free-list allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int HEAP_BYTES_DEF = 4096;
  localparam int NODE_BYTES_DEF = 8;
  localparam int HDR_BYTES_DEF  = 8;

  // internal address/arithmetic width, covers offsets beyond the heap end
  localparam int XW = 18;
  localparam int WW = 16;

  localparam logic [WW-1:0] MARK_WORD = 16'hFFFE;
  localparam logic [WW-1:0] NIL_LINK  = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [12:0] request_size;
    logic [11:0] block_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] block_address;
    logic [12:0] free_bytes;
    logic [9:0]  free_nodes;
  } res_t;

  // word access command to the heap memory
  typedef struct packed {
    logic          go;
    logic          wr;
    logic [XW-1:0] addr;
    logic [WW-1:0] wdata;
  } mem_cmd_t;

  typedef struct packed {
    logic          done;
    logic          init_busy;
    logic [WW-1:0] rdata;
  } mem_st_t;

endpackage
`default_nettype wire

FILE: hdl/ffa_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_mem
// Byte heap memory with 16-bit little-endian word access and init sweep.
// ----------------------------------------------------------------------------
module ffa_mem #(
  parameter int HEAP_BYTES = ffa_pkg::HEAP_BYTES_DEF,
  parameter int NODE_BYTES = ffa_pkg::NODE_BYTES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ffa_pkg::mem_cmd_t cmd,
  output ffa_pkg::mem_st_t      st
);

  localparam int AW = $clog2(HEAP_BYTES);
  localparam logic [ffa_pkg::XW-1:0] HEAP_X = ffa_pkg::XW'(HEAP_BYTES);
  localparam logic [15:0] INIT_SIZE = 16'(HEAP_BYTES - NODE_BYTES);

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_W1   = 4'b0010,
    M_R1   = 4'b0100,
    M_R2   = 4'b1000
  } mstate_t;

  mstate_t state;
  logic [7:0] heap_mem [HEAP_BYTES];
  logic [7:0] q;
  logic [7:0] lo;
  logic [AW-1:0] init_cnt;
  logic init_busy;

  logic we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [7:0] wdata;
  logic oob;
  logic [ffa_pkg::XW-1:0] addr_hi;

  assign addr_hi = cmd.addr + ffa_pkg::XW'(1);
  assign oob = addr_hi >= HEAP_X;

  always_comb begin
    we = 1'b0;
    waddr = cmd.addr[AW-1:0];
    wdata = cmd.wdata[7:0];
    raddr = cmd.addr[AW-1:0];
    if (init_busy) begin
      we = 1'b1;
      waddr = init_cnt;
      case (init_cnt)
        AW'(0): wdata = INIT_SIZE[7:0];
        AW'(1): wdata = INIT_SIZE[15:8];
        AW'(2), AW'(3): wdata = 8'hFF;
        default: wdata = 8'h00;
      endcase
    end else begin
      case (state)
        M_IDLE: begin
          we = cmd.go && cmd.wr && !oob;
        end
        M_W1: begin
          we = 1'b1;
          waddr = addr_hi[AW-1:0];
          wdata = cmd.wdata[15:8];
        end
        M_R1: begin
          raddr = addr_hi[AW-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      heap_mem[waddr] <= wdata;
    end
    q <= heap_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      init_busy <= 1'b1;
      init_cnt <= '0;
    end else begin
      if (init_busy) begin
        init_cnt <= init_cnt + AW'(1);
        if (init_cnt == AW'(HEAP_BYTES - 1)) begin
          init_busy <= 1'b0;
        end
      end
      case (state)
        M_IDLE: begin
          if (cmd.go && !oob && !init_busy) begin
            state <= cmd.wr ? M_W1 : M_R1;
          end
        end
        M_W1: state <= M_IDLE;
        M_R1: begin
          lo <= q;
          state <= M_R2;
        end
        M_R2: state <= M_IDLE;
        default: state <= M_IDLE;
      endcase
    end
  end

  always_comb begin
    st.init_busy = init_busy;
    st.done = (state == M_IDLE && cmd.go && oob) || state == M_W1 || state == M_R2;
    st.rdata = (state == M_R2) ? {q, lo} : '0;
  end

endmodule
`default_nettype wire

FILE: hdl/first_fit_free_list_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_unit
// First-fit allocator with the free list kept inside a byte heap memory.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  request  | in_valid / in_ready   | in_data  (ffa_pkg::req_t)
//  result   | out_valid / out_ready | out_data (ffa_pkg::res_t)
//
//  Every 16-bit heap access is done byte by byte on the byte-wide heap: a write
//  passes M_IDLE and M_W1, a read M_IDLE, M_R1 and M_R2; a request reads and
//  writes list words while walking the list, plus the walk summing free bytes and nodes.
//  After reset every heap byte is swept; no request is taken during the sweep.
//  One request is in flight at a time; a held result stalls only completion.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator_unit #(
  parameter int HEAP_BYTES = ffa_pkg::HEAP_BYTES_DEF,
  parameter int NODE_BYTES = ffa_pkg::NODE_BYTES_DEF,
  parameter int HDR_BYTES  = ffa_pkg::HDR_BYTES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ffa_pkg::req_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ffa_pkg::res_t      out_data
);

  localparam int XW = ffa_pkg::XW;
  localparam int WL = HEAP_BYTES / 4 + 2;
  localparam int SW = $clog2(WL + 1);
  localparam logic [XW-1:0] NODE_X = XW'(NODE_BYTES);
  localparam logic [XW-1:0] HDR_X = XW'(HDR_BYTES);
  localparam logic [XW-1:0] HEAP_X = XW'(HEAP_BYTES);
  localparam logic [XW-1:0] NODE_MAX = XW'(HEAP_BYTES - NODE_BYTES);
  localparam logic [XW-1:0] TWO_X = XW'(2);
  localparam logic [XW-1:0] NIL_X = XW'(ffa_pkg::NIL_LINK);
  localparam logic [SW-1:0] WL_S = SW'(WL);

  typedef enum logic [27:0] {
    IDLE   = 28'h0000001,
    A_CHK  = 28'h0000002,
    A_RSZ  = 28'h0000004,
    A_RLNK = 28'h0000008,
    A_DEC  = 28'h0000010,
    A_WNN  = 28'h0000020,
    A_WNL  = 28'h0000040,
    A_WPRV = 28'h0000080,
    A_WSZ  = 28'h0000100,
    A_WMK  = 28'h0000200,
    F_RMK  = 28'h0000400,
    F_RSZ  = 28'h0000800,
    F_WSZ  = 28'h0001000,
    F_WLNK = 28'h0002000,
    C_OUT  = 28'h0004000,
    C_IN   = 28'h0008000,
    C_RNX  = 28'h0010000,
    C_RHS  = 28'h0020000,
    C_RNS  = 28'h0040000,
    C_WSZ  = 28'h0080000,
    C_RNL  = 28'h0100000,
    C_WLNK = 28'h0200000,
    C_ADV  = 28'h0400000,
    S_CHK  = 28'h0800000,
    S_RSZ  = 28'h1000000,
    S_RLNK = 28'h2000000,
    OUTP   = 28'h4000000,
    S_INIT = 28'h8000000
  } state_t;

  state_t state;
  logic [XW-1:0] head;
  logic [XW-1:0] cur;
  logic [XW-1:0] prev;
  logic [XW-1:0] aux;
  logic [15:0] nxt;
  logic [15:0] sz;
  logic [12:0] req;
  logic [SW-1:0] steps;
  logic [12:0] bytes;
  logic [9:0] nodes;
  ffa_pkg::status_t status;
  logic [11:0] addr;

  ffa_pkg::mem_cmd_t mcmd;
  ffa_pkg::mem_st_t mst;

  ffa_mem #(
    .HEAP_BYTES(HEAP_BYTES),
    .NODE_BYTES(NODE_BYTES)
  ) u_mem (
    .clk(clk),
    .rst(rst),
    .cmd(mcmd),
    .st(mst)
  );

  logic [XW-1:0] rd_x;
  logic [XW-1:0] sz_x;
  logic [XW-1:0] req_x;
  logic [XW-1:0] boff_x;
  logic [XW-1:0] nn;
  logic fits;
  logic split;
  logic cur_node;
  logic walk_end;

  assign rd_x = XW'(mst.rdata);
  assign sz_x = XW'(sz);
  assign req_x = XW'(req);
  assign boff_x = XW'(in_data.block_offset);
  assign nn = cur + HDR_X + req_x;
  assign fits = sz_x + NODE_X >= req_x + HDR_X;
  assign split = sz_x >= req_x + HDR_X;
  assign cur_node = cur <= NODE_MAX;
  assign walk_end = !cur_node || steps >= WL_S;

  always_comb begin
    mcmd.go = 1'b1;
    mcmd.wr = 1'b0;
    mcmd.addr = cur;
    mcmd.wdata = '0;
    case (state)
      A_RSZ, F_RSZ, C_RHS, S_RSZ: mcmd.addr = cur;
      A_RLNK, F_RMK, C_RNX, C_ADV, S_RLNK: mcmd.addr = cur + TWO_X;
      A_WNN: begin
        mcmd.wr = 1'b1;
        mcmd.addr = nn;
        mcmd.wdata = 16'(sz_x - HDR_X - req_x);
      end
      A_WNL: begin
        mcmd.wr = 1'b1;
        mcmd.addr = nn + TWO_X;
        mcmd.wdata = nxt;
      end
      A_WPRV: begin
        mcmd.go = prev <= NODE_MAX;
        mcmd.wr = 1'b1;
        mcmd.addr = prev + TWO_X;
        mcmd.wdata = aux[15:0];
      end
      A_WSZ: begin
        mcmd.wr = 1'b1;
        mcmd.wdata = split ? 16'(req_x) : 16'(sz_x + NODE_X - HDR_X);
      end
      A_WMK: begin
        mcmd.wr = 1'b1;
        mcmd.addr = cur + TWO_X;
        mcmd.wdata = ffa_pkg::MARK_WORD;
      end
      F_WSZ: begin
        mcmd.wr = 1'b1;
        mcmd.wdata = (sz_x + HDR_X >= NODE_X) ? 16'(sz_x + HDR_X - NODE_X) : 16'h0000;
      end
      F_WLNK: begin
        mcmd.wr = 1'b1;
        mcmd.addr = cur + TWO_X;
        mcmd.wdata = (head <= NODE_MAX) ? head[15:0] : ffa_pkg::NIL_LINK;
      end
      C_RNS: mcmd.addr = XW'(nxt);
      C_WSZ: begin
        mcmd.wr = 1'b1;
        mcmd.wdata = 16'(sz_x + NODE_X + aux);
      end
      C_RNL: mcmd.addr = XW'(nxt) + TWO_X;
      C_WLNK: begin
        mcmd.wr = 1'b1;
        mcmd.addr = cur + TWO_X;
        mcmd.wdata = aux[15:0];
      end
      default: mcmd.go = 1'b0;
    endcase
  end

  assign in_ready = (state == IDLE) && !mst.init_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      head <= '0;
      out_valid <= 1'b0;
      steps <= '0;
    end else begin
      if (out_valid && out_ready && state != OUTP) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_valid && in_ready) begin
            req <= in_data.request_size;
            status <= ffa_pkg::ST_OK;
            addr <= '0;
            steps <= '0;
            if (in_data.operation == ffa_pkg::OP_ALLOC) begin
              prev <= NIL_X;
              cur <= head;
              state <= A_CHK;
            end else if (boff_x < HDR_X || boff_x - HDR_X > NODE_MAX || boff_x > HEAP_X) begin
              status <= ffa_pkg::ST_BAD_FREE;
              state <= S_INIT;
            end else begin
              cur <= boff_x - HDR_X;
              state <= F_RMK;
            end
          end
        end
        A_CHK: begin
          if (walk_end) begin
            status <= ffa_pkg::ST_NO_FIT;
            state <= S_INIT;
          end else begin
            state <= A_RSZ;
          end
        end
        A_RSZ: if (mst.done) begin
          sz <= mst.rdata;
          state <= A_RLNK;
        end
        A_RLNK: if (mst.done) begin
          nxt <= mst.rdata;
          if (fits) begin
            state <= A_DEC;
          end else begin
            prev <= cur;
            cur <= rd_x;
            steps <= steps + SW'(1);
            state <= A_CHK;
          end
        end
        A_DEC: begin
          aux <= split ? nn : XW'(nxt);
          state <= split ? A_WNN : A_WPRV;
        end
        A_WNN: if (mst.done) state <= A_WNL;
        A_WNL: if (mst.done) state <= A_WPRV;
        A_WPRV: begin
          if (prev > NODE_MAX) begin
            head <= aux;
            state <= A_WSZ;
          end else if (mst.done) begin
            state <= A_WSZ;
          end
        end
        A_WSZ: if (mst.done) state <= A_WMK;
        A_WMK: if (mst.done) begin
          addr <= 12'(cur + HDR_X);
          state <= S_INIT;
        end
        F_RMK: if (mst.done) begin
          if (mst.rdata != ffa_pkg::MARK_WORD) begin
            status <= ffa_pkg::ST_BAD_FREE;
            state <= S_INIT;
          end else begin
            state <= F_RSZ;
          end
        end
        F_RSZ: if (mst.done) begin
          sz <= mst.rdata;
          state <= F_WSZ;
        end
        F_WSZ: if (mst.done) state <= F_WLNK;
        F_WLNK: if (mst.done) begin
          head <= cur;
          steps <= '0;
          state <= C_OUT;
        end
        C_OUT: state <= walk_end ? S_INIT : C_IN;
        C_IN: state <= (steps >= WL_S) ? C_ADV : C_RNX;
        C_RNX: if (mst.done) begin
          nxt <= mst.rdata;
          state <= (rd_x <= NODE_MAX) ? C_RHS : C_ADV;
        end
        C_RHS: if (mst.done) begin
          sz <= mst.rdata;
          state <= (cur + NODE_X + rd_x != XW'(nxt)) ? C_ADV : C_RNS;
        end
        C_RNS: if (mst.done) begin
          aux <= rd_x;
          state <= C_WSZ;
        end
        C_WSZ: if (mst.done) state <= C_RNL;
        C_RNL: if (mst.done) begin
          aux <= rd_x;
          state <= C_WLNK;
        end
        C_WLNK: if (mst.done) begin
          steps <= steps + SW'(1);
          state <= C_IN;
        end
        C_ADV: if (mst.done) begin
          cur <= rd_x;
          steps <= steps + SW'(1);
          state <= C_OUT;
        end
        S_INIT: begin
          cur <= head;
          steps <= '0;
          bytes <= '0;
          nodes <= '0;
          state <= S_CHK;
        end
        S_CHK: state <= walk_end ? OUTP : S_RSZ;
        S_RSZ: if (mst.done) begin
          bytes <= bytes + mst.rdata[12:0];
          state <= S_RLNK;
        end
        S_RLNK: if (mst.done) begin
          cur <= rd_x;
          nodes <= nodes + 10'd1;
          steps <= steps + SW'(1);
          state <= S_CHK;
        end
        OUTP: begin
          if (!out_valid || out_ready) begin
            out_data.status <= status;
            out_data.block_address <= addr;
            out_data.free_bytes <= bytes;
            out_data.free_nodes <= nodes;
            out_valid <= 1'b1;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_no_access_in_sweep: assert property (@(posedge clk) disable iff (rst)
    mcmd.go |-> !mst.init_busy)
    else $error("heap access during init sweep");

  a_addr_only_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != ffa_pkg::ST_OK) |-> out_data.block_address == 12'd0)
    else $error("address reported with failing status");

  // the merge walk may step once past the bound when leaving its inner loop
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    steps <= WL_S + SW'(1))
    else $error("walk counter past bound");

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the first-fit free-list allocator. A local heap model predicts
// status, block address, free byte and node counts for every request; results
// are checked in order, with random gaps on both the request and result side.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int HEAP  = 4096;
  localparam int NODE  = 8;
  localparam int HDR   = 8;
  localparam int WALK_MAX = HEAP / 4 + 2;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  ffa_pkg::req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ffa_pkg::res_t out_data;

  first_fit_free_list_allocator_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #10 clk = ~clk;

  logic [7:0] heap_bytes[HEAP];
  int unsigned free_head;
  ffa_pkg::req_t pending_reqs[$];
  ffa_pkg::res_t expected_results[$];
  int unsigned live_blocks[$];
  int unsigned mismatches = 0;
  int unsigned n_alloc_ok = 0, n_no_fit = 0, n_bad_free = 0, n_free_ok = 0;
  int unsigned n_checked = 0;
  bit hold_sender = 1'b0;
  bit stim_done = 1'b0;

  function automatic int unsigned word_rd(int unsigned a);
    if (a + 1 >= HEAP) return 0;
    return {heap_bytes[a + 1], heap_bytes[a]};
  endfunction

  function automatic void word_wr(int unsigned a, int unsigned v);
    if (a + 1 >= HEAP) return;
    heap_bytes[a] = v[7:0];
    heap_bytes[a + 1] = v[15:8];
  endfunction

  function automatic bit on_heap(int unsigned p);
    return p <= HEAP - NODE;
  endfunction

  function automatic void heap_init();
    foreach (heap_bytes[i]) heap_bytes[i] = 8'h00;
    free_head = 0;
    word_wr(0, HEAP - NODE);
    word_wr(2, ffa_pkg::NIL_LINK);
  endfunction

  function automatic void merge_adjacent();
    int unsigned h, nx, steps;
    h = free_head;
    steps = 0;
    while (on_heap(h) && steps < WALK_MAX) begin
      while (steps < WALK_MAX) begin
        nx = word_rd(h + 2);
        if (!on_heap(nx)) break;
        if (h + NODE + word_rd(h) != nx) break;
        word_wr(h, (word_rd(h) + NODE + word_rd(nx)) & 16'hFFFF);
        word_wr(h + 2, word_rd(nx + 2));
        steps++;
      end
      h = word_rd(h + 2);
      steps++;
    end
  endfunction

  function automatic ffa_pkg::res_t predict_alloc_free(ffa_pkg::req_t r);
    ffa_pkg::res_t o;
    int unsigned prv, cur, steps, sz, nxt, repl, asz, nn, h, s, ns, p, bytes, nodes;
    int unsigned req;
    bit found;
    o = '0;
    o.status = ffa_pkg::ST_OK;
    if (r.operation == ffa_pkg::OP_ALLOC) begin
      req = r.request_size;
      prv = ffa_pkg::NIL_LINK;
      cur = free_head;
      steps = 0;
      found = 0;
      while (on_heap(cur) && steps < WALK_MAX) begin
        if (word_rd(cur) + NODE >= req + HDR) begin
          found = 1;
          break;
        end
        prv = cur;
        cur = word_rd(cur + 2);
        steps++;
      end
      if (!found) begin
        o.status = ffa_pkg::ST_NO_FIT;
      end else begin
        sz = word_rd(cur);
        nxt = word_rd(cur + 2);
        if (sz >= req + HDR) begin
          nn = cur + HDR + req;
          word_wr(nn, sz - HDR - req);
          word_wr(nn + 2, nxt);
          repl = nn;
          asz = req;
        end else begin
          repl = nxt;
          asz = (sz + NODE - HDR) & 16'hFFFF;
        end
        if (on_heap(prv)) word_wr(prv + 2, repl);
        else free_head = repl;
        word_wr(cur, asz);
        word_wr(cur + 2, ffa_pkg::MARK_WORD);
        o.block_address = 12'((cur + HDR) & 12'hFFF);
      end
    end else begin
      o.status = ffa_pkg::ST_BAD_FREE;
      if (r.block_offset >= HDR) begin
        h = r.block_offset - HDR;
        if (on_heap(h) && h + HDR <= HEAP && word_rd(h + 2) == ffa_pkg::MARK_WORD) begin
          s = word_rd(h);
          ns = (s + HDR >= NODE) ? s + HDR - NODE : 0;
          word_wr(h, ns & 16'hFFFF);
          word_wr(h + 2, on_heap(free_head) ? free_head : ffa_pkg::NIL_LINK);
          free_head = h;
          merge_adjacent();
          o.status = ffa_pkg::ST_OK;
        end
      end
    end
    p = free_head;
    steps = 0;
    bytes = 0;
    nodes = 0;
    while (on_heap(p) && steps < WALK_MAX) begin
      bytes += word_rd(p);
      nodes++;
      p = word_rd(p + 2);
      steps++;
    end
    o.free_bytes = 13'(bytes);
    o.free_nodes = 10'(nodes);
    return o;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t: %s mismatch: got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic ffa_pkg::req_t alloc_req(int unsigned sz);
    ffa_pkg::req_t r;
    r.operation = ffa_pkg::OP_ALLOC;
    r.request_size = 13'(sz);
    r.block_offset = 12'($urandom);
    return r;
  endfunction

  function automatic ffa_pkg::req_t free_req(int unsigned off);
    ffa_pkg::req_t r;
    r.operation = ffa_pkg::OP_FREE;
    r.request_size = 13'($urandom);
    r.block_offset = 12'(off);
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 45) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  function automatic int unsigned rand_size();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 70) return $urandom_range(0, 64);
    if (k < 92) return $urandom_range(65, 600);
    return $urandom_range(0, 8191);
  endfunction

  // driver
  int unsigned send_gap = 0;
  ffa_pkg::req_t cur_req;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_ready) begin
    end else begin
      if (in_valid) begin
        cur_req = pending_reqs.pop_front();
        expected_results.push_back(predict_alloc_free(cur_req));
        send_gap = gap_len();
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0 && !hold_sender) begin
        in_valid <= 1'b1;
        in_data <= pending_reqs[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  int unsigned recv_gap = 0;
  ffa_pkg::res_t want;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = expected_results.pop_front();
          n_checked++;
          if (out_data.status != want.status)
            report_mismatch("status", out_data.status, want.status);
          if (out_data.block_address != want.block_address)
            report_mismatch("block_address", out_data.block_address, want.block_address);
          if (out_data.free_bytes != want.free_bytes)
            report_mismatch("free_bytes", out_data.free_bytes, want.free_bytes);
          if (out_data.free_nodes != want.free_nodes)
            report_mismatch("free_nodes", out_data.free_nodes, want.free_nodes);
          if (want.status == ffa_pkg::ST_NO_FIT) n_no_fit++;
          else if (want.status == ffa_pkg::ST_BAD_FREE) n_bad_free++;
        end
        recv_gap = gap_len();
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus is generated against a shadow predictor so that frees target
  // live blocks; the shadow is reset before the driver starts predicting.
  initial begin
    int unsigned k, idx, off;
    ffa_pkg::res_t r;
    ffa_pkg::req_t q;
    heap_init();
    // directed: extremes, zero-size, no fit, whole-node grab, bad frees
    q = alloc_req(0);         pending_reqs.push_back(q);
    q = alloc_req(8191);      pending_reqs.push_back(q);
    q = alloc_req(4096);      pending_reqs.push_back(q);
    q = free_req(0);          pending_reqs.push_back(q);
    q = free_req(7);          pending_reqs.push_back(q);
    q = free_req(4095);       pending_reqs.push_back(q);
    q = free_req(8);          pending_reqs.push_back(q);
    q = free_req(8);          pending_reqs.push_back(q);
    q = alloc_req(100);       pending_reqs.push_back(q);
    q = alloc_req(200);       pending_reqs.push_back(q);
    q = alloc_req(50);        pending_reqs.push_back(q);
    q = free_req(124);        pending_reqs.push_back(q);
    q = free_req(8);          pending_reqs.push_back(q);
    q = free_req(116);        pending_reqs.push_back(q);
    q = alloc_req(4088);      pending_reqs.push_back(q);
    q = free_req(4095);       pending_reqs.push_back(q);
    q = free_req(8);          pending_reqs.push_back(q);
    q = alloc_req(4082);      pending_reqs.push_back(q);
    q = free_req(8);          pending_reqs.push_back(q);
    q = alloc_req(4080);      pending_reqs.push_back(q);
    q = free_req(8);          pending_reqs.push_back(q);
    q = free_req(12'hAAA);    pending_reqs.push_back(q);
    q = free_req(12'h555);    pending_reqs.push_back(q);
    foreach (pending_reqs[i]) r = predict_alloc_free(pending_reqs[i]);
    for (int n = 0; n < 800; n++) begin
      k = $urandom_range(0, 99);
      if (k < 50 || live_blocks.size() == 0) begin
        q = alloc_req(rand_size());
      end else if (k < 90) begin
        idx = $urandom_range(0, live_blocks.size() - 1);
        q = free_req(live_blocks[idx]);
        live_blocks.delete(idx);
      end else begin
        off = (k < 95 && live_blocks.size() > 0) ?
              live_blocks[$urandom_range(0, live_blocks.size() - 1)] + $urandom_range(1, 3)
              : $urandom_range(0, 4095);
        q = free_req(off);
      end
      r = predict_alloc_free(q);
      if (q.operation == ffa_pkg::OP_ALLOC && r.status == ffa_pkg::ST_OK)
        live_blocks.push_back(r.block_address);
      if (q.operation == ffa_pkg::OP_ALLOC && r.status == ffa_pkg::ST_OK) n_alloc_ok++;
      if (q.operation == ffa_pkg::OP_FREE && r.status == ffa_pkg::ST_OK) n_free_ok++;
      pending_reqs.push_back(q);
    end
    heap_init();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // let the directed part drain fully once before the random traffic
    wait (pending_reqs.size() <= 800);
    @(posedge clk);
    hold_sender = 1'b1;
    wait (expected_results.size() == 0 && !in_valid);
    hold_sender = 1'b0;
    wait (pending_reqs.size() == 0);
    wait (expected_results.size() == 0);
    repeat (50) @(posedge clk);
    $display("checked %0d results: %0d allocations, %0d frees, %0d no-fit, %0d bad frees",
             n_checked, n_alloc_ok, n_free_ok, n_no_fit, n_bad_free);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2s;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: first_fit_free_list_allocator_unit.f
hdl/ffa_pkg.sv
hdl/ffa_mem.sv
hdl/first_fit_free_list_allocator_unit.sv
bench/tb_top.sv
